[design/dlr_pkg.sv]
`default_nettype none
package dlr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int PERIOD_BITS = 6;

  localparam logic [PERIOD_BITS-1:0] DASH_RESET = PERIOD_BITS'(10);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } line_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  plot;
    logic                  done_res;
  } pixel_item_t;

endpackage
`default_nettype wire

[design/dlr_step.sv]
`default_nettype none
module dlr_step
  import dlr_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         dash_we,
  input  wire logic [PERIOD_BITS-1:0] dash_data,
  input  wire                         accept,
  input  wire line_item_t             item,
  output pixel_item_t                 result
);

  logic [PERIOD_BITS-1:0]   dash_period;
  logic [COORD_BITS-1:0]    cur_x, cur_y, cur_x_next, cur_y_next;
  logic signed [ERR_BITS-1:0] err_term, inc_move, inc_stay;
  logic signed [ERR_BITS-1:0] err_term_next, inc_move_next, inc_stay_next;
  logic                     dir_x_neg, dir_y_neg, x_major, active;
  logic                     dir_x_neg_next, dir_y_neg_next, x_major_next, active_next;
  logic [COORD_BITS-1:0]    moves_left, moves_left_next;
  logic [PERIOD_BITS-1:0]   dash_phase, dash_phase_next;

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      adx, ady, maj, mnr;
  logic signed [ERR_BITS-1:0] maj_e, mnr_e;
  logic                       bump;
  logic [COORD_BITS-1:0]      step_x, step_y;
  logic [PERIOD_BITS-1:0]     period_m1;
  logic [PERIOD_BITS:0]       phase_p1;
  logic                       dash_vis;

  // endpoint setup
  always_comb begin
    dx    = signed'({1'b0, item.x_end}) - signed'({1'b0, item.x_start});
    dy    = signed'({1'b0, item.y_end}) - signed'({1'b0, item.y_start});
    adx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    maj   = (adx >= ady) ? adx : ady;
    mnr   = (adx >= ady) ? ady : adx;
    maj_e = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, maj});
    mnr_e = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, mnr});
  end

  // walk step and dash pattern
  always_comb begin
    bump      = !err_term[ERR_BITS-1];
    step_x    = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
    step_y    = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    period_m1 = dash_period - 1'b1;
    phase_p1  = {1'b0, dash_phase} + 1'b1;
    dash_vis  = (dash_phase != '0) && (dash_phase != period_m1) &&
                (dash_period >= PERIOD_BITS'(2));
  end

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    err_term_next   = err_term;
    inc_move_next   = inc_move;
    inc_stay_next   = inc_stay;
    dir_x_neg_next  = dir_x_neg;
    dir_y_neg_next  = dir_y_neg;
    x_major_next    = x_major;
    moves_left_next = moves_left;
    dash_phase_next = dash_phase;
    active_next     = active;
    result.plot     = 1'b0;
    result.done_res = 1'b1;
    case (item.cmd)
      CMD_START: begin
        dir_x_neg_next  = dx[COORD_BITS];
        dir_y_neg_next  = dy[COORD_BITS];
        x_major_next    = adx >= ady;
        err_term_next   = (mnr_e <<< 1) - maj_e;
        inc_move_next   = (mnr_e - maj_e) <<< 1;
        inc_stay_next   = mnr_e <<< 1;
        cur_x_next      = item.x_start;
        cur_y_next      = item.y_start;
        moves_left_next = maj;
        dash_phase_next = '0;
        active_next     = maj != '0;
        result.plot     = 1'b1;
        result.done_res = maj == '0;
      end
      CMD_STEP: begin
        if (active) begin
          err_term_next = err_term + (bump ? inc_move : inc_stay);
          if (x_major) begin
            cur_x_next = step_x;
            if (bump) cur_y_next = step_y;
          end else begin
            cur_y_next = step_y;
            if (bump) cur_x_next = step_x;
          end
          dash_phase_next = (phase_p1 >= {1'b0, dash_period}) ? '0 :
                            phase_p1[PERIOD_BITS-1:0];
          moves_left_next = moves_left - 1'b1;
          active_next     = moves_left_next != '0;
          result.plot     = dash_vis;
          result.done_res = moves_left_next == '0;
        end
      end
      default: begin
      end
    endcase
    result.pixel_x = cur_x_next;
    result.pixel_y = cur_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_period <= DASH_RESET;
    end else if (dash_we) begin
      dash_period <= dash_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      err_term   <= '0;
      inc_move   <= '0;
      inc_stay   <= '0;
      dir_x_neg  <= 1'b0;
      dir_y_neg  <= 1'b0;
      x_major    <= 1'b0;
      moves_left <= '0;
      dash_phase <= '0;
      active     <= 1'b0;
    end else if (accept) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      err_term   <= err_term_next;
      inc_move   <= inc_move_next;
      inc_stay   <= inc_stay_next;
      dir_x_neg  <= dir_x_neg_next;
      dir_y_neg  <= dir_y_neg_next;
      x_major    <= x_major_next;
      moves_left <= moves_left_next;
      dash_phase <= dash_phase_next;
      active     <= active_next;
    end
  end

`ifndef ASSERT_OFF
  a_active_has_moves: assert property (@(posedge clk) disable iff (rst)
    active |-> moves_left != '0)
    else $error("active line with no moves left");

  a_last_move_ends: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == CMD_STEP && active && moves_left == COORD_BITS'(1)
    |=> !active)
    else $error("line still active after its last move");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == CMD_START |=> dash_phase == '0)
    else $error("dash phase not cleared by start");
`endif

endmodule
`default_nettype wire

[design/dlr_skid.sv]
`default_nettype none
module dlr_skid
  import dlr_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire pixel_item_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output pixel_item_t       out_data
);

  logic        skid_valid;
  pixel_item_t skid_data;
  logic        out_take, in_take;

  assign in_stall = skid_valid;
  assign out_take = out_valid && !out_stall;
  assign in_take  = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_data <= skid_data;
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_take |=> out_valid && !skid_valid)
    else $error("skid item not moved to output");

  a_fill_skid: assert property (@(posedge clk) disable iff (rst)
    in_take && out_valid && out_stall |=> skid_valid)
    else $error("item accepted under stall not held in skid");
`endif

endmodule
`default_nettype wire

[design/dashed_line_rasterizer_core.sv]
`default_nettype none
// Dashed Bresenham line rasterizer. A start item (cmd = CMD_START) loads two
// endpoints and returns the start pixel, always plotted; each step item
// (cmd = CMD_STEP) advances one pixel along the major axis, bumping the minor
// axis when the error term is non-negative. Moves whose index i satisfies
// i mod dash_period == 0 or dash_period-1 come back with plot = 0, and
// done_res flags the final pixel; steps past the end repeat the last pixel
// with plot = 0 and done_res = 1. Throughput is one item per clock while
// line_stall is low: each item is resolved by one add and compare on the
// walk registers and lands in the output register, or in the skid slot when
// the output is stalled. A two-entry output buffer (result register plus skid
// slot) keeps line_stall registered and lets a new item in while the previous
// pixel waits. dash_period resets to 10. The user must write it via dash_we
// and dash_data only while no line item is in flight; nothing enforces it.
module dashed_line_rasterizer_core
  import dlr_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst,
  // dash period register
  input  wire                         dash_we,
  input  wire logic [PERIOD_BITS-1:0] dash_data,
  // line command items
  input  wire                         line_valid,
  output logic                        line_stall,
  input  wire line_item_t             line_data,
  // pixel result items
  output logic                        pix_valid,
  input  wire                         pix_stall,
  output pixel_item_t                 pix_data
);

  logic        line_accept;
  pixel_item_t step_result;

  // an item is taken whenever the skid slot is free
  assign line_accept = line_valid && !line_stall;

  // walk state, dash phase and the per-item next-pixel logic
  dlr_step u_step (
    .clk       (clk),
    .rst       (rst),
    .dash_we   (dash_we),
    .dash_data (dash_data),
    .accept    (line_accept),
    .item      (line_data),
    .result    (step_result)
  );

  // result register with skid slot
  dlr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line_valid),
    .in_stall  (line_stall),
    .in_data   (step_result),
    .out_valid (pix_valid),
    .out_stall (pix_stall),
    .out_data  (pix_data)
  );

endmodule
`default_nettype wire

[tb/dashed_line_rasterizer_checker.sv]
`timescale 1ns / 1ps
module dashed_line_rasterizer_checker
  import dlr_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         dash_we,
  input  wire logic [PERIOD_BITS-1:0] dash_data,
  input  wire                         line_valid,
  input  wire                         line_stall,
  input  wire line_item_t             line_data,
  input  wire                         pix_valid,
  input  wire                         pix_stall,
  input  wire pixel_item_t            pix_data,
  output int                          mismatches,
  output int                          pending
);

  // shadow of the line walker
  logic [PERIOD_BITS-1:0] period;
  logic [COORD_BITS-1:0]  pos_x, pos_y;
  int                     err_acc, err_diag, err_flat, steps_left;
  logic                   neg_x, neg_y, major_x, drawing;
  logic [PERIOD_BITS-1:0] phase;

  pixel_item_t pixel_expect_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void clear_walk();
    period     = DASH_RESET;
    pos_x      = '0;
    pos_y      = '0;
    err_acc    = 0;
    err_diag   = 0;
    err_flat   = 0;
    steps_left = 0;
    neg_x      = 1'b0;
    neg_y      = 1'b0;
    major_x    = 1'b0;
    drawing    = 1'b0;
    phase      = '0;
  endfunction

  function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] v,
                                                  input logic neg);
    return neg ? v - 1'b1 : v + 1'b1;
  endfunction

  // next pixel for one accepted line item; updates the shadow state
  function automatic pixel_item_t rasterize_item(input line_item_t it);
    pixel_item_t px;
    int dx, dy, maj, mnr;
    logic bump;
    px.plot     = 1'b0;
    px.done_res = 1'b1;
    if (it.cmd == CMD_START) begin
      dx       = int'(it.x_end) - int'(it.x_start);
      dy       = int'(it.y_end) - int'(it.y_start);
      neg_x    = dx < 0;
      neg_y    = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      major_x  = dx >= dy;
      maj      = major_x ? dx : dy;
      mnr      = major_x ? dy : dx;
      err_acc  = 2 * mnr - maj;
      err_diag = 2 * (mnr - maj);
      err_flat = 2 * mnr;
      pos_x    = it.x_start;
      pos_y    = it.y_start;
      steps_left = maj;
      phase    = '0;
      drawing  = maj != 0;
      px.plot     = 1'b1;
      px.done_res = !drawing;
    end else if (drawing) begin
      bump    = err_acc >= 0;
      err_acc = err_acc + (bump ? err_diag : err_flat);
      if (major_x) begin
        pos_x = nudge(pos_x, neg_x);
        if (bump) pos_y = nudge(pos_y, neg_y);
      end else begin
        pos_y = nudge(pos_y, neg_y);
        if (bump) pos_x = nudge(pos_x, neg_x);
      end
      px.plot = (phase != 0) && (phase != PERIOD_BITS'(period - 1'b1)) && (period >= 2);
      phase   = (int'(phase) + 1 >= int'(period)) ? '0 : phase + 1'b1;
      steps_left  = steps_left - 1;
      px.done_res = steps_left == 0;
      drawing     = !px.done_res;
    end
    px.pixel_x = pos_x;
    px.pixel_y = pos_y;
    return px;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_item_t want;
    if (rst) begin
      clear_walk();
      pixel_expect_q.delete();
    end else begin
      if (dash_we) period = dash_data;
      if (pix_valid && !pix_stall) begin
        if (pixel_expect_q.size() == 0) begin
          report($sformatf("unexpected pixel item x=%0d y=%0d",
                           pix_data.pixel_x, pix_data.pixel_y));
        end else begin
          want = pixel_expect_q.pop_front();
          if (pix_data.pixel_x !== want.pixel_x)
            report($sformatf("pixel_x got %0d want %0d", pix_data.pixel_x, want.pixel_x));
          if (pix_data.pixel_y !== want.pixel_y)
            report($sformatf("pixel_y got %0d want %0d", pix_data.pixel_y, want.pixel_y));
          if (pix_data.plot !== want.plot)
            report($sformatf("plot got %b want %b", pix_data.plot, want.plot));
          if (pix_data.done_res !== want.done_res)
            report($sformatf("done_res got %b want %b", pix_data.done_res, want.done_res));
        end
      end
      if (line_valid && !line_stall) pixel_expect_q.push_back(rasterize_item(line_data));
    end
    pending = pixel_expect_q.size();
  end

endmodule

[tb/dashed_line_rasterizer_core_tb.sv]
`timescale 1ns / 1ps
module dashed_line_rasterizer_core_tb;
  import dlr_pkg::*;

  localparam int ITEMS_PER_PHASE = 155;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

  logic                   clk;
  logic                   rst;
  logic                   dash_we;
  logic [PERIOD_BITS-1:0] dash_data;
  logic                   line_valid;
  logic                   line_stall;
  line_item_t             line_data;
  logic                   pix_valid;
  logic                   pix_stall;
  pixel_item_t            pix_data;

  int mismatches;
  int pending;
  bit quiet;   // no gaps and no back-pressure in the closing phase
  int sent;    // line items accepted so far

  // dash periods walked through, extremes and the out-of-range low values included
  logic [PERIOD_BITS-1:0] period_plan [8];

  dashed_line_rasterizer_core u_top (
    .clk        (clk),
    .rst        (rst),
    .dash_we    (dash_we),
    .dash_data  (dash_data),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_data  (line_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data)
  );

  dashed_line_rasterizer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .dash_we    (dash_we),
    .dash_data  (dash_data),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_data  (line_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: ~2000 items finish well under this.
  initial begin
    #5000000;
    $display("dashed_line_rasterizer_core regression: fail");
    $finish;
  end

  // Pixel side back-pressure: random stall bursts.
  initial begin
    pix_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        pix_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        pix_stall <= 1'b0;
      end
    end
  end

  // Present one item at a falling edge and hold it until the block takes it.
  // Valid stays high across back-to-back items unless a gap is inserted.
  task automatic send_item(input line_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      line_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    line_valid <= 1'b1;
    line_data  <= it;
    @(posedge clk);
    while (line_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_start(input int x1, input int y1, input int x2, input int y2);
    line_item_t it;
    it.cmd     = CMD_START;
    it.x_start = COORD_BITS'(x1);
    it.y_start = COORD_BITS'(y1);
    it.x_end   = COORD_BITS'(x2);
    it.y_end   = COORD_BITS'(y2);
    send_item(it);
  endtask

  // Step items carry junk coordinates; the block must ignore them.
  task automatic send_steps(input int n);
    line_item_t it;
    repeat (n) begin
      it         = line_item_t'({$urandom, $urandom});
      it.cmd     = CMD_STEP;
      send_item(it);
    end
  endtask

  // Let every outstanding pixel come back.
  task automatic drain();
    line_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_BITS-1:0] p);
    dash_we   <= 1'b1;
    dash_data <= p;
    @(negedge clk);
    dash_we   <= 1'b0;
  endtask

  // Endpoint within +/-span of base, reflected to stay on the raster.
  function automatic int offset_coord(input int base, input int span);
    int d;
    d = $urandom_range(0, 2 * span) - span;
    return (base + d >= 0 && base + d <= COORD_MAX) ? base + d : base - d;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // One line: mostly start + exactly enough steps (plus a stray step or two
  // past the end); some are cut short by the next start, a few are long
  // lines walked only part way, and a few are zero length.
  task automatic random_line();
    int x1, y1, x2, y2, dx, dy, maj, n, kind;
    x1   = pick_coord();
    y1   = pick_coord();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      x2 = pick_coord();
      y2 = pick_coord();
    end else if (kind == 1) begin
      x2 = x1;
      y2 = y1;
    end else begin
      x2 = offset_coord(x1, 40);
      y2 = offset_coord(y1, 40);
    end
    dx  = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy  = (y2 > y1) ? y2 - y1 : y1 - y2;
    maj = (dx > dy) ? dx : dy;
    if (kind == 0)
      n = $urandom_range(0, 60);
    else if ($urandom_range(0, 7) == 0)
      n = $urandom_range(0, maj);
    else
      n = maj + $urandom_range(0, 2);
    send_start(x1, y1, x2, y2);
    send_steps(n);
  endtask

  initial begin
    int target;
    rst        = 1'b1;
    dash_we    = 1'b0;
    dash_data  = '0;
    line_valid = 1'b0;
    line_data  = '0;
    quiet      = 1'b0;
    sent       = 0;
    period_plan = '{6'd2, 6'd63, 6'd0, 6'd1, 6'd3, 6'd7, 6'd2, DASH_RESET};
    period_plan[6] = PERIOD_BITS'($urandom_range(2, 63));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, at the reset period of 10.
    send_start(0, 0, 0, 0);                 // zero-length line
    send_steps(2);                          // steps with no line active
    send_start(0, 0, COORD_MAX, COORD_MAX); // full diagonal
    send_steps(3);
    send_start(COORD_MAX, 0, 0, COORD_MAX); // restart mid-line, x down / y up
    send_steps(2);
    send_start(COORD_MAX, COORD_MAX, 0, 0); // both axes decreasing
    send_steps(2);
    send_start(10, 10, 13, 11);             // short shallow line
    send_steps(4);                          // last one runs past the end
    send_start(100, 200, 98, 190);          // steep, both negative
    send_steps(3);
    send_start(0, COORD_MAX, COORD_MAX, COORD_MAX - 1);
    send_steps(1);
    drain();

    // Random phases, one per dash period. Each phase leaves a line half
    // drawn so the next period takes effect in the middle of a line.
    foreach (period_plan[p]) begin
      if (p == 7) quiet = 1'b1;
      set_period(period_plan[p]);
      send_steps($urandom_range(5, 60));
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) random_line();
      send_start(pick_coord(), pick_coord(), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX));
      send_steps($urandom_range(1, 30));
      drain();
    end

    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("dashed_line_rasterizer_core regression: pass");
    end else begin
      $display("dashed_line_rasterizer_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dlr_pkg.sv
design/dlr_step.sv
design/dlr_skid.sv
design/dashed_line_rasterizer_core.sv
tb/dashed_line_rasterizer_checker.sv
tb/dashed_line_rasterizer_core_tb.sv
